FILE: rtl/core/depth_pixel_to_point_assert.svh
// Assertion macros for the depth pixel back-projection block.
// Expects signals named clk and rst in the module that includes this file.
`ifndef DEPTH_PIXEL_TO_POINT_ASSERT_SVH
`define DEPTH_PIXEL_TO_POINT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dpp_pkg.sv
// Shared types, constants and saturation helper for depth_pixel_to_point.
// No dependencies.
package dpp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ROT_X     = 3'd0;
  localparam logic [2:0] REG_ROT_Y     = 3'd1;
  localparam logic [2:0] REG_ROT_Z     = 3'd2;
  localparam logic [2:0] REG_TRANS     = 3'd3;
  localparam logic [2:0] REG_CENTER    = 3'd4;
  localparam logic [2:0] REG_INV_FOCAL = 3'd5;
  localparam logic [2:0] REG_SCALE     = 3'd6;
  localparam logic [2:0] REG_SENTINEL  = 3'd7;

  // Width of the intermediate that is clamped to signed 32 bits
  localparam int SAT_W = 52;
  localparam logic signed [SAT_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -52'sd2147483648;

  // Enables of the three transform stages, one per stage
  typedef struct packed {
    logic s6;
    logic s7;
    logic s8;
  } xform_en_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/dpp_row_xform.sv
// One row of the rigid transform: three products, sum, shift, offset, clamp.
// Depends on dpp_pkg for the stage-enable struct and sat32.
module dpp_row_xform (
  input  logic                  clk,
  input  logic [47:0]           rot_row,
  input  logic [19:0]           trans,
  input  logic signed [31:0]    xc,
  input  logic signed [31:0]    yc,
  input  logic signed [32:0]    zc,
  input  logic                  invalid,
  input  dpp_pkg::xform_en_t    en,
  output logic signed [31:0]    point
);

  logic signed [48:0] prod_x;
  logic signed [48:0] prod_y;
  logic signed [48:0] prod_z;
  logic signed [50:0] acc;
  logic signed [dpp_pkg::SAT_W-1:0] total;

  // Stage 6: one multiplier per column of the row
  always_ff @(posedge clk) begin
    if (en.s6) begin
      prod_x <= 49'($signed(rot_row[15:0])) * 49'(xc);
      prod_y <= 49'($signed(rot_row[31:16])) * 49'(yc);
      prod_z <= 49'($signed(rot_row[47:32])) * 49'(zc);
    end
  end

  // Stage 7: sum the three products
  always_ff @(posedge clk) begin
    if (en.s7) begin
      acc <= 51'(prod_x) + 51'(prod_y) + 51'(prod_z);
    end
  end

  // Floor shift out the Q2.14 fraction, add translation scaled to Q16.16
  assign total = dpp_pkg::SAT_W'(acc >>> 14) +
                 dpp_pkg::SAT_W'($signed({trans, 4'b0000}));

  // Stage 8: clamp, force zero for sentinel depths
  always_ff @(posedge clk) begin
    if (en.s8) begin
      point <= invalid ? 32'sd0 : dpp_pkg::sat32(total);
    end
  end

endmodule

FILE: rtl/core/depth_pixel_to_point.sv
// depth_pixel_to_point: back-projects one depth pixel to a transformed 3-D point.
// Throughput one item per cycle while the output accepts, set by the eight-stage
// multiplier pipeline with per-stage stall. Reset (rst, synchronous, active high)
// empties the pipeline and loads every configuration register with its default.
// Uses dpp_pkg, dpp_row_xform, the assert header.
`include "depth_pixel_to_point_assert.svh"

module depth_pixel_to_point #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  // pixel input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  input  logic [15:0]           depth,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  // point output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    point_x,
  output logic signed [31:0]    point_y,
  output logic signed [31:0]    point_z,
  output logic                  invalid,
  output logic [7:0]            red_out,
  output logic [7:0]            green_out,
  output logic [7:0]            blue_out
);

  localparam int NSTAGE = 8;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [47:0] rot_x;
  logic [47:0] rot_y;
  logic [47:0] rot_z;
  logic [59:0] trans;
  logic [63:0] center;
  logic [63:0] inv_focal;
  logic [31:0] scale;
  logic [31:0] sentinel;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_x     <= 48'd16384;
      rot_y     <= 48'd1073741824;
      rot_z     <= 48'd70368744177664;
      trans     <= '0;
      center    <= '0;
      inv_focal <= '0;
      scale     <= 32'h0100_0000;
      sentinel  <= 32'hFFFF_0000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dpp_pkg::REG_ROT_X:     rot_x     <= cfg_data[47:0];
        dpp_pkg::REG_ROT_Y:     rot_y     <= cfg_data[47:0];
        dpp_pkg::REG_ROT_Z:     rot_z     <= cfg_data[47:0];
        dpp_pkg::REG_TRANS:     trans     <= cfg_data[59:0];
        dpp_pkg::REG_CENTER:    center    <= cfg_data;
        dpp_pkg::REG_INV_FOCAL: inv_focal <= cfg_data;
        dpp_pkg::REG_SCALE:     scale     <= cfg_data[31:0];
        dpp_pkg::REG_SENTINEL:  sentinel  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control: each stage loads when it is empty or its successor loads,
  // so bubbles collapse and a stall at the output holds only full stages.
  // ---------------------------------------------------------------------------
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] en;
  logic [NSTAGE:1] vld_in;

  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in = {vld[NSTAGE-1:1], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NSTAGE];

  // Colour and sentinel flag travel with the item through every stage
  logic [23:0] rgb [1:NSTAGE];
  logic [NSTAGE:1] inv;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rgb[1] <= {red_in, green_in, blue_in};
      inv[1] <= (depth == sentinel[15:0]) || (depth == sentinel[31:16]);
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (en[k]) begin
        rgb[k] <= rgb[k-1];
        inv[k] <= inv[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: raw depth times scale; pixel offsets from the optical centre
  // ---------------------------------------------------------------------------
  logic [47:0] dprod1;
  logic [31:0] umag1, vmag1;
  logic        uneg1, vneg1;
  logic signed [32:0] du, dv;

  // Coordinate in Q16.16 minus centre, one sign bit above 32
  assign du = $signed({1'b0, 32'({column, 16'h0000})}) - $signed({1'b0, center[31:0]});
  assign dv = $signed({1'b0, 32'({row, 16'h0000})})    - $signed({1'b0, center[63:32]});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dprod1 <= 48'(depth) * 48'(scale);
      uneg1  <= du[32];
      vneg1  <= dv[32];
      umag1  <= du[32] ? 32'(-du) : du[31:0];
      vmag1  <= dv[32] ? 32'(-dv) : dv[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: depth in metres, Q16.16, clamped to 32 bits
  // ---------------------------------------------------------------------------
  logic [31:0] zm2;
  logic [31:0] umag2, vmag2;
  logic        uneg2, vneg2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      zm2   <= (dprod1[47:40] != 8'd0) ? 32'hFFFF_FFFF : dprod1[39:8];
      umag2 <= umag1;
      vmag2 <= vmag1;
      uneg2 <= uneg1;
      vneg2 <= vneg1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: depth over focal length, one 32x32 multiplier per axis
  // ---------------------------------------------------------------------------
  logic [63:0] zfx_full, zfy_full;
  logic [31:0] zfx3, zfy3, zm3;
  logic [31:0] umag3, vmag3;
  logic        uneg3, vneg3;

  assign zfx_full = 64'(zm2) * 64'(inv_focal[31:0]);
  assign zfy_full = 64'(zm2) * 64'(inv_focal[63:32]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      zfx3  <= zfx_full[63:32];
      zfy3  <= zfy_full[63:32];
      zm3   <= zm2;
      umag3 <= umag2;
      vmag3 <= vmag2;
      uneg3 <= uneg2;
      vneg3 <= vneg2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: offset magnitude times depth over focal length
  // ---------------------------------------------------------------------------
  logic [63:0] xprod4, yprod4;
  logic [31:0] zm4;
  logic        uneg4, vneg4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      xprod4 <= 64'(umag3) * 64'(zfx3);
      yprod4 <= 64'(vmag3) * 64'(zfy3);
      zm4    <= zm3;
      uneg4  <= uneg3;
      vneg4  <= vneg3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: drop the fraction with floor rounding, restore sign, clamp
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] camera_coord(input logic [63:0] prod,
                                                      input logic        neg);
    logic [48:0] q;
    logic signed [dpp_pkg::SAT_W-1:0] s;
    // Floor of a negative value: round the magnitude up when bits drop off
    q = {1'b0, prod[63:16]} + 49'(neg && (prod[15:0] != 16'h0000));
    s = $signed({3'b000, q});
    if (neg) begin
      s = -s;
    end
    return dpp_pkg::sat32(s);
  endfunction

  logic signed [31:0] xc5, yc5;
  logic signed [32:0] zc5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      xc5 <= camera_coord(xprod4, uneg4);
      yc5 <= camera_coord(yprod4, vneg4);
      zc5 <= $signed({1'b0, zm4});
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 6 to 8: rotation and translation, one unit per output axis
  // ---------------------------------------------------------------------------
  dpp_pkg::xform_en_t xen;

  assign xen.s6 = en[6];
  assign xen.s7 = en[7];
  assign xen.s8 = en[8];

  dpp_row_xform u_row_x (
    .clk     (clk),
    .rot_row (rot_x),
    .trans   (trans[19:0]),
    .xc      (xc5),
    .yc      (yc5),
    .zc      (zc5),
    .invalid (inv[7]),
    .en      (xen),
    .point   (point_x)
  );

  dpp_row_xform u_row_y (
    .clk     (clk),
    .rot_row (rot_y),
    .trans   (trans[39:20]),
    .xc      (xc5),
    .yc      (yc5),
    .zc      (zc5),
    .invalid (inv[7]),
    .en      (xen),
    .point   (point_y)
  );

  dpp_row_xform u_row_z (
    .clk     (clk),
    .rot_row (rot_z),
    .trans   (trans[59:40]),
    .xc      (xc5),
    .yc      (yc5),
    .zc      (zc5),
    .invalid (inv[7]),
    .en      (xen),
    .point   (point_z)
  );

  assign invalid   = inv[NSTAGE];
  assign red_out   = rgb[NSTAGE][23:16];
  assign green_out = rgb[NSTAGE][15:8];
  assign blue_out  = rgb[NSTAGE][7:0];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic coords_zero;

  assign coords_zero = (point_x == 32'sd0) && (point_y == 32'sd0) && (point_z == 32'sd0);

  // A sentinel depth must come out with all coordinates zeroed
  `DPP_ASSERT_NOW(a_invalid_zero, out_valid && invalid, coords_zero, "sentinel item not zeroed")
  // With the output stage empty nothing can hold the input back
  `DPP_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input stalled with an empty output stage")
  // An accepted item must occupy the first stage on the next cycle
  `DPP_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, vld[1], "accepted item lost at the first stage")

endmodule

FILE: bench/depth_pixel_to_point_tb.sv
// Self-checking bench for depth_pixel_to_point: pixels in, transformed points out.
// Predicts each point with its own fixed-point model of the back-projection;
// depends on dpp_pkg and the depth_pixel_to_point RTL only.
module depth_pixel_to_point_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = 12;
  localparam int SETTLE = 16;         // a little over the pipeline
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic signed [127:0] S32_HI = 128'sd2147483647;
  localparam logic signed [127:0] S32_LO = -128'sd2147483648;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [15:0]        depth;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               invalid;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } point_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [15:0]        depth;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               invalid;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;

  // Shadow copy of the configuration registers, kept at their stored widths
  logic [47:0] cfg_rot_x, cfg_rot_y, cfg_rot_z;
  logic [59:0] cfg_trans;
  logic [63:0] cfg_center;
  logic [63:0] cfg_inv_focal;
  logic [31:0] cfg_scale;
  logic [31:0] cfg_sentinel;

  // Next register setting to load, indexed by register index
  logic [63:0] plan [8];

  point_t pending_points[$];
  int     fault_count = 0;
  int     pixels_sent = 0;
  int     points_seen = 0;
  int     invalid_seen = 0;
  int     settings_loaded = 0;
  int     cycle_count = 0;
  bit     steady = 1'b0;   // when set, neither side starts an idle gap
  int     stall_left = 0;

  depth_pixel_to_point #(.COORD_BITS(COORD_W)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .column    (column),
    .row       (row),
    .depth     (depth),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .invalid   (invalid),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Point predictor
  // ---------------------------------------------------------------------------

  // Clamp a wide signed intermediate to the signed 32-bit range.
  function automatic logic signed [127:0] clamp_s32(input logic signed [127:0] v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  // Camera-frame offset along one axis: floor((coord - centre) * zf), Q16.16.
  // The arithmetic shift on a signed value rounds toward minus infinity.
  function automatic logic signed [127:0] ray_offset(input logic [COORD_W-1:0] coord,
                                                      input logic [31:0] centre,
                                                      input logic [31:0] zf);
    logic signed [127:0] offset, zscale, prod;
    offset = signed'({{(112-COORD_W){1'b0}}, coord, 16'b0}) - signed'({96'b0, centre});
    zscale = signed'({96'b0, zf});
    prod = offset * zscale;
    return clamp_s32(prod >>> 16);
  endfunction

  // One output axis: Q2.14 rotation row dotted with the camera point, plus
  // the Q8.12 translation moved up to Q16.16.
  function automatic logic signed [31:0] rotate_row(input logic [47:0] rot,
                                                    input logic signed [127:0] xc,
                                                    input logic signed [127:0] yc,
                                                    input logic signed [127:0] zc,
                                                    input logic [19:0] shift);
    logic signed [127:0] acc, offset, clamped;
    acc = signed'(rot[15:0]) * xc + signed'(rot[31:16]) * yc + signed'(rot[47:32]) * zc;
    offset = signed'(shift);
    clamped = clamp_s32((acc >>> 14) + (offset <<< 4));
    return clamped[31:0];
  endfunction

  function automatic point_t project_pixel(input pixel_t p);
    point_t              pt;
    logic [47:0]         scaled;
    logic [31:0]         zm;
    logic [63:0]         prod;
    logic [31:0]         zfx, zfy;
    logic signed [127:0] xc, yc, zc;
    pt.red = p.red;
    pt.green = p.green;
    pt.blue = p.blue;
    pt.invalid = (p.depth == cfg_sentinel[15:0]) || (p.depth == cfg_sentinel[31:16]);
    pt.x = '0;
    pt.y = '0;
    pt.z = '0;
    if (!pt.invalid) begin
      // metres in Q16.16, pinned at the top of the unsigned range
      scaled = {32'b0, p.depth} * {16'b0, cfg_scale};
      zm = (scaled[47:40] != 0) ? 32'hFFFF_FFFF : scaled[39:8];
      prod = {32'b0, zm} * {32'b0, cfg_inv_focal[31:0]};
      zfx = prod[63:32];
      prod = {32'b0, zm} * {32'b0, cfg_inv_focal[63:32]};
      zfy = prod[63:32];
      xc = ray_offset(p.column, cfg_center[31:0], zfx);
      yc = ray_offset(p.row, cfg_center[63:32], zfy);
      zc = signed'({96'b0, zm});
      pt.x = rotate_row(cfg_rot_x, xc, yc, zc, cfg_trans[19:0]);
      pt.y = rotate_row(cfg_rot_y, xc, yc, zc, cfg_trans[39:20]);
      pt.z = rotate_row(cfg_rot_z, xc, yc, zc, cfg_trans[59:40]);
    end
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none, often a few cycles, now and then a long wait.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t pixel(input int c, input int r, input int d, input logic [23:0] rgb);
    pixel_t p;
    p.column = c[COORD_W-1:0];
    p.row = r[COORD_W-1:0];
    p.depth = d[15:0];
    {p.red, p.green, p.blue} = rgb;
    return p;
  endfunction

  // Random pixel; lean on the live sentinel codes so invalid points turn up often.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     r;
    p.column = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    p.row = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    r = $urandom_range(0, 99);
    if (r < 8) p.depth = cfg_sentinel[15:0];
    else if (r < 16) p.depth = cfg_sentinel[31:16];
    else if (r < 20) p.depth = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else p.depth = 16'($urandom_range(0, 16'hFFFF));
    {p.red, p.green, p.blue} = 24'($urandom_range(0, 24'hFF_FFFF));
    return p;
  endfunction

  function automatic logic [15:0] random_rot_entry();
    int v;
    // mostly within +/-1.0, sometimes anywhere in Q2.14
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 16'hFFFF));
    v = $urandom_range(0, 32768);
    v = v - 16384;
    return v[15:0];
  endfunction

  // Send one pixel. Entered and left just after a falling edge; valid is left
  // high so that a back-to-back pixel needs no second assignment in the step.
  task automatic send_pixel(input pixel_t p);
    int     gap;
    point_t want;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    column   <= p.column;
    row      <= p.row;
    depth    <= p.depth;
    red_in   <= p.red;
    green_in <= p.green;
    blue_in  <= p.blue;
    do @(posedge clk); while (!in_ready);
    want = project_pixel(p);
    pending_points.push_back(want);
    pixels_sent++;
    if (want.invalid) invalid_seen++;
    @(negedge clk);
  endtask

  // Drop valid, let every point come back, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Load every register from plan, one write per cycle, only while idle.
  task automatic load_plan();
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= plan[i];
      case (i[2:0])
        dpp_pkg::REG_ROT_X:     cfg_rot_x = plan[i][47:0];
        dpp_pkg::REG_ROT_Y:     cfg_rot_y = plan[i][47:0];
        dpp_pkg::REG_ROT_Z:     cfg_rot_z = plan[i][47:0];
        dpp_pkg::REG_TRANS:     cfg_trans = plan[i][59:0];
        dpp_pkg::REG_CENTER:    cfg_center = plan[i];
        dpp_pkg::REG_INV_FOCAL: cfg_inv_focal = plan[i];
        dpp_pkg::REG_SCALE:     cfg_scale = plan[i][31:0];
        dpp_pkg::REG_SENTINEL:  cfg_sentinel = plan[i][31:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    settings_loaded++;
  endtask

  // A plausible depth camera: VGA-ish optics, millimetre depth, mild rotation.
  task automatic plan_camera();
    plan[dpp_pkg::REG_ROT_X]     = {16'h0, 16'sd0, -16'sd9830, 16'sd13107};
    plan[dpp_pkg::REG_ROT_Y]     = {16'h0, 16'sd0, 16'sd13107, 16'sd9830};
    plan[dpp_pkg::REG_ROT_Z]     = {16'h0, 16'sd16384, 16'sd0, 16'sd0};
    plan[dpp_pkg::REG_TRANS]     = {4'h0, 20'sd8192, -20'sd5120, 20'sd2048};
    plan[dpp_pkg::REG_CENTER]    = {32'd15695872, 32'd20938752};   // (319.5, 239.5)
    plan[dpp_pkg::REG_INV_FOCAL] = {32'd8180898, 32'd8180898};     // 1/525
    plan[dpp_pkg::REG_SCALE]     = 64'd16777;                      // 1 mm per unit
    plan[dpp_pkg::REG_SENTINEL]  = {32'h0, 16'd10000, 16'd0};
  endtask

  task automatic plan_random_camera();
    for (int i = 0; i < 3; i++)
      plan[dpp_pkg::REG_ROT_X + i] = {16'h0, random_rot_entry(), random_rot_entry(),
                                      random_rot_entry()};
    plan[dpp_pkg::REG_TRANS] = {4'h0, 20'($urandom), 20'($urandom), 20'($urandom)};
    plan[dpp_pkg::REG_CENTER] = {32'($urandom_range(0, 32'h0FFF_0000)),
                                 32'($urandom_range(0, 32'h0FFF_0000))};
    for (int a = 0; a < 2; a++) begin
      int r;
      logic [31:0] f;
      r = $urandom_range(0, 99);
      if (r < 85) f = $urandom_range(1073741, 42949672);   // focal 4000 .. 100 px
      else if (r < 95) f = $urandom;
      else f = '0;
      plan[dpp_pkg::REG_INV_FOCAL][a*32 +: 32] = f;
    end
    plan[dpp_pkg::REG_INV_FOCAL] = plan[dpp_pkg::REG_INV_FOCAL];
    plan[dpp_pkg::REG_SCALE] = ($urandom_range(0, 4) == 0) ? 64'($urandom)
                                                            : 64'($urandom_range(1678, 167772));
    plan[dpp_pkg::REG_SENTINEL] = {32'h0, 16'($urandom),
                                   $urandom_range(0, 1) ? 16'h0 : 16'($urandom)};
    if ($urandom_range(0, 9) == 0)
      plan[dpp_pkg::REG_SENTINEL][31:16] = plan[dpp_pkg::REG_SENTINEL][15:0];
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: identity rotation, unit scale, zero inverse focal lengths,
  // so x and y collapse to zero and z is the raw depth in metres.
  task automatic test_reset_defaults();
    cfg_rot_x = 48'd16384;
    cfg_rot_y = 48'h0000_4000_0000;
    cfg_rot_z = 48'h4000_0000_0000;
    cfg_trans = '0;
    cfg_center = '0;
    cfg_inv_focal = '0;
    cfg_scale = 32'h0100_0000;
    cfg_sentinel = 32'hFFFF_0000;
    send_pixel(pixel(0, 0, 16'h0000, 24'h000000));         // too close
    send_pixel(pixel(4095, 4095, 16'hFFFF, 24'hFFFFFF));   // too far
    send_pixel(pixel(0, 4095, 16'h0001, 24'hFF00FF));
    send_pixel(pixel(4095, 0, 16'hFFFE, 24'h00FF00));
    send_pixel(pixel(2048, 2048, 16'h8000, 24'hA5A5A5));
    send_pixel(pixel(1365, 2730, 16'h7FFF, 24'h5A5A5A));
    send_pixel(pixel(2730, 1365, 16'h5555, 24'h123456));
    send_pixel(pixel(1, 1, 16'hAAAA, 24'hEDCBA9));
  endtask

  task automatic test_camera_directed();
    plan_camera();
    load_plan();
    send_pixel(pixel(0, 0, 1500, 24'h102030));
    send_pixel(pixel(4095, 4095, 1500, 24'hFFFFFF));
    send_pixel(pixel(319, 239, 1000, 24'h000000));         // near the optical axis
    send_pixel(pixel(320, 240, 16'hFFFF, 24'h808080));     // far but not a sentinel
    send_pixel(pixel(640, 480, 1, 24'h0F0F0F));
    send_pixel(pixel(100, 400, 0, 24'hF0F0F0));            // too close
    send_pixel(pixel(600, 20, 10000, 24'h3C3C3C));         // too far
    send_pixel(pixel(4095, 0, 9999, 24'hC3C3C3));
  endtask

  // Both codes the same: one value is invalid, its neighbours are not.
  task automatic test_shared_sentinel();
    // upper bits are dropped
    plan[dpp_pkg::REG_SENTINEL] = {32'hFFFF_FFFF, 16'h1234, 16'h1234};
    load_plan();
    send_pixel(pixel(10, 20, 16'h1234, 24'h010203));
    send_pixel(pixel(10, 20, 16'h1233, 24'h040506));
    send_pixel(pixel(10, 20, 16'h1235, 24'h070809));
  endtask

  // Every stage pushed to its limits so each clamp is hit.
  task automatic test_saturation();
    plan[dpp_pkg::REG_ROT_X]     = {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    plan[dpp_pkg::REG_ROT_Y]     = {16'hFFFF, 16'h8000, 16'h8000, 16'h8000};
    plan[dpp_pkg::REG_ROT_Z]     = {16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF};
    plan[dpp_pkg::REG_TRANS]     = {4'hF, 20'h7FFFF, 20'h80000, 20'h7FFFF};
    plan[dpp_pkg::REG_CENTER]    = {32'hFFFF_FFFF, 32'h0000_0000};
    plan[dpp_pkg::REG_INV_FOCAL] = 64'hFFFF_FFFF_FFFF_FFFF;
    plan[dpp_pkg::REG_SCALE]     = 64'hFFFF_FFFF_FFFF_FFFF;
    plan[dpp_pkg::REG_SENTINEL]  = 64'h5555_AAAA;
    load_plan();
    send_pixel(pixel(0, 0, 16'hFFFF, 24'hFFFFFF));
    send_pixel(pixel(4095, 4095, 16'hFFFF, 24'h000000));
    send_pixel(pixel(4095, 0, 16'h0000, 24'h0000FF));
    send_pixel(pixel(0, 4095, 16'h0001, 24'hFF0000));
    send_pixel(pixel(2048, 2048, 16'hAAAA, 24'h00FF00));   // invalid even here
    send_pixel(pixel(4095, 4095, 16'h0100, 24'h777777));
  endtask

  // Random pixels over a run of plausible random camera settings.
  task automatic test_random_camera(input int settings, input int per_setting);
    for (int s = 0; s < settings; s++) begin
      plan_random_camera();
      load_plan();
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < per_setting; i++) send_pixel(random_pixel());
      steady = 1'b0;
    end
  endtask

  // Registers all clear, all set (unused upper bits too) and fully random.
  task automatic test_random_extremes(input int per_setting);
    for (int s = 0; s < 3; s++) begin
      for (int i = 0; i < 8; i++) begin
        case (s)
          0: plan[i] = '0;
          1: plan[i] = '1;
          default: plan[i] = {$urandom, $urandom};
        endcase
      end
      load_plan();
      steady = (s == 1);
      for (int i = 0; i < per_setting; i++) send_pixel(random_pixel());
      steady = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall out_ready at random, starting no new stall while steady
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted point against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && out_valid && out_ready) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("point arrived with no pixel pending");
        fault_count++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $error("point_x expected %0d got %0d", want.x, point_x);
          fault_count++;
        end
        if (point_y !== want.y) begin
          $error("point_y expected %0d got %0d", want.y, point_y);
          fault_count++;
        end
        if (point_z !== want.z) begin
          $error("point_z expected %0d got %0d", want.z, point_z);
          fault_count++;
        end
        if (invalid !== want.invalid) begin
          $error("invalid expected %0d got %0d", want.invalid, invalid);
          fault_count++;
        end
        if (red_out !== want.red) begin
          $error("red_out expected %0d got %0d", want.red, red_out);
          fault_count++;
        end
        if (green_out !== want.green) begin
          $error("green_out expected %0d got %0d", want.green, green_out);
          fault_count++;
        end
        if (blue_out !== want.blue) begin
          $error("blue_out expected %0d got %0d", want.blue, blue_out);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    column    = '0;
    row       = '0;
    depth     = '0;
    red_in    = '0;
    green_in  = '0;
    blue_in   = '0;
    // hold reset, then release on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_camera_directed();
    test_shared_sentinel();
    test_saturation();
    test_random_camera(5, 200);
    test_random_extremes(100);

    // drain, then leave room for any stray point to show up
    wait_idle();
    if (pending_points.size() != 0) fault_count++;
    $display("Covered %0d pixels (%0d invalid) over %0d register settings; %0d points checked.",
             pixels_sent, invalid_seen, settings_loaded + 1, points_seen);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
